// ----- rtl/tldf_pkg.sv -----
// shared constants, types and helpers of the text line display framer
// no dependencies; used by the packer and the top level
package tldf_pkg;

   // geometry of the text buffer and the display store
   localparam int LINE_LEN    = 24;
   localparam int NUM_ROWS    = 3;
   localparam int STORE_DEPTH = NUM_ROWS * LINE_LEN;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int TEXT_AW     = $clog2(LINE_LEN);
   localparam int CNT_W       = $clog2(LINE_LEN + 1);
   localparam int ROW_W       = $clog2(NUM_ROWS);

   // message layout
   localparam int HDR_LEN    = 7;
   localparam int HDR_IW     = $clog2(HDR_LEN);
   localparam int ZD_LEN     = 6;
   localparam int TRAIL_LEN  = 3;
   localparam int STREAM_MAX = HDR_LEN + 2 * LINE_LEN + TRAIL_LEN + ZD_LEN + TRAIL_LEN;
   localparam int POS_W      = $clog2(STREAM_MAX + 1);

   // byte codes
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam logic [7:0] NL_BYTE     = 8'h0A;
   localparam logic [7:0] SPACE_BYTE  = 8'h20;
   localparam logic [7:0] DIGIT_ONE   = 8'h31;
   localparam logic [7:0] DIGIT_THREE = 8'h33;

   // message headers
   localparam logic [7:0] HDR_A [HDR_LEN] =
      '{8'h0D, 8'h41, 8'h4F, 8'h30, 8'h30, 8'h30, 8'h31};
   localparam logic [7:0] HDR_B [HDR_LEN] =
      '{8'h0D, 8'h42, 8'h4F, 8'h30, 8'h30, 8'h30, 8'h31};
   localparam logic [7:0] HDR_Z [ZD_LEN] =
      '{8'h0D, 8'h5A, 8'h44, 8'h30, 8'h30, 8'h31};

   // uppercase hex character of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = 8'h30 + {4'h0, v};
      end else begin
         r = 8'h37 + {4'h0, v};
      end
      return r;
   endfunction

   // checksum of the status message, which has no body
   function automatic logic [7:0] zd_checksum();
      logic [7:0] s;
      s = 8'h00;
      for (int i = 0; i < ZD_LEN; i++) begin
         s = s + HDR_Z[i];
      end
      return s;
   endfunction

   localparam logic [7:0] ZD_SUM = zd_checksum();

   // one byte of the outgoing stream
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } tldf_byte_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_EMIT  = 3'b100
   } tldf_state_type;

endpackage

// ----- rtl/tldf_if.sv -----
// valid/ready channel interfaces of the text line display framer
// no dependencies
interface tldf_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface tldf_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] first_char;
   logic [7:0] second_char;
   logic       second_valid;
   logic       last_of_run;

   modport source (output valid, output first_char, output second_char,
                   output second_valid, output last_of_run, input ready);
   modport sink (input valid, input first_char, input second_char,
                 input second_valid, input last_of_run, output ready);
endinterface

// ----- rtl/text_line_display_framer.sv -----
// channel   | dir | payload                                            | transaction
// req_ch    | in  | rx_byte[7:0]                                       | valid & ready
// rsp_ch    | out | first_char, second_char, second_valid, last_of_run | valid & ready
//
// after a terminator, a line digit starts a copy pass that writes the text into the
// display store, padding with spaces, and then sends the stream through a store read
// and a byte stage: 67 bytes (34 transactions) for lines 1/2, 43 bytes (22
// transactions) for line 3.
// reset is synchronous; the display store reads as spaces through three row flags
// until a row is first written, so there is no clearing pass. a stall on rsp_ch
// holds the byte pipeline; req_ch is ready only in the idle state, not while a line is copied or sent.
// depends on tldf_pkg, tldf_if and tldf_packer
module text_line_display_framer import tldf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tldf_req_if.sink   req_ch,
   tldf_rsp_if.source rsp_ch
);

   tldf_state_type     state_ff, state_in;
   logic               awaiting_ff, awaiting_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ROW_W-1:0]   line_ff, line_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [POS_W-1:0]   p_ff, p_in;
   logic [POS_W-1:0]   p1_ff, p1_in;
   logic               s1_vld_ff, s1_vld_in;
   logic [7:0]         sum_ff, sum_in;
   logic [NUM_ROWS-1:0] row_vld_ff, row_vld_in;
   logic               rd_blank_ff;
   logic [7:0]         store_q_ff;
   logic [7:0]         text_q_ff;

   // memories
   logic [7:0] text_mem [LINE_LEN];
   logic [7:0] store_mem [STORE_DEPTH];

   logic               req_take;
   logic               is_digit;
   logic               text_we;
   logic [TEXT_AW-1:0] text_waddr;
   logic               text_re;
   logic [TEXT_AW-1:0] text_raddr;
   logic               store_we;
   logic [STORE_AW-1:0] store_waddr;
   logic [7:0]         store_wdata;
   logic [CNT_W-1:0]   wr_col;
   logic               store_re;
   logic [STORE_AW-1:0] store_raddr;
   logic [ROW_W-1:0]   rd_row;
   logic               is_b;
   logic [POS_W-1:0]   body_len;
   logic [POS_W-1:0]   hex_pos;
   logic [POS_W-1:0]   stream_len;
   logic [POS_W-1:0]   offset0;
   logic               in_body0;
   logic [POS_W-1:0]   zi;
   logic               adv;
   logic               issue;
   logic               byte_take;
   tldf_byte_type      byte1;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign is_digit     = (req_ch.rx_byte >= DIGIT_ONE) && (req_ch.rx_byte <= DIGIT_THREE);

   // frame geometry of the selected line
   assign is_b       = (line_ff == ROW_W'(2));
   assign body_len   = is_b ? POS_W'(LINE_LEN) : POS_W'(2 * LINE_LEN);
   assign hex_pos    = POS_W'(HDR_LEN) + body_len;
   assign stream_len = hex_pos + POS_W'(TRAIL_LEN + ZD_LEN + TRAIL_LEN);

   // text buffer write on a stored text byte
   assign text_we    = req_take && !awaiting_ff && (req_ch.rx_byte != CR_BYTE)
                       && (count_ff < CNT_W'(LINE_LEN));
   assign text_waddr = count_ff[TEXT_AW-1:0];

   // copy pass: read text entry k and write store entry k-1, read in the previous cycle
   assign text_re     = (state_ff == ST_WRITE) && (k_ff < CNT_W'(LINE_LEN));
   assign text_raddr  = k_ff[TEXT_AW-1:0];
   assign wr_col      = k_ff - CNT_W'(1);
   assign store_we    = (state_ff == ST_WRITE) && (k_ff != '0);
   assign store_waddr = STORE_AW'(line_ff) * STORE_AW'(LINE_LEN) + STORE_AW'(wr_col);
   assign store_wdata = (wr_col < count_ff) ? text_q_ff : SPACE_BYTE;

   // byte pipeline: stage 0 issues the store read, stage 1 forms the byte
   assign adv      = !s1_vld_ff || byte_take;
   assign issue    = (state_ff == ST_EMIT) && (p_ff != stream_len) && adv;
   assign offset0  = p_ff - POS_W'(HDR_LEN);
   assign in_body0 = (p_ff >= POS_W'(HDR_LEN)) && (p_ff < hex_pos);
   assign store_re = issue && in_body0;
   assign store_raddr = is_b ? STORE_AW'(2 * LINE_LEN) + STORE_AW'(offset0)
                             : STORE_AW'(offset0);

   always_comb begin
      if (is_b) begin
         rd_row = ROW_W'(2);
      end else if (offset0 < POS_W'(LINE_LEN)) begin
         rd_row = ROW_W'(0);
      end else begin
         rd_row = ROW_W'(1);
      end
   end

   // stage 1 byte selection
   assign zi = p1_ff - (hex_pos + POS_W'(TRAIL_LEN));

   always_comb begin
      byte1.last = (p1_ff == stream_len - POS_W'(1));
      priority if (p1_ff < POS_W'(HDR_LEN)) begin
         byte1.data = is_b ? HDR_B[p1_ff[HDR_IW-1:0]] : HDR_A[p1_ff[HDR_IW-1:0]];
      end else if (p1_ff < hex_pos) begin
         byte1.data = rd_blank_ff ? SPACE_BYTE : store_q_ff;
      end else if (p1_ff == hex_pos) begin
         byte1.data = hex_char(sum_ff[7:4]);
      end else if (p1_ff == hex_pos + POS_W'(1)) begin
         byte1.data = hex_char(sum_ff[3:0]);
      end else if (p1_ff == hex_pos + POS_W'(2)) begin
         byte1.data = NL_BYTE;
      end else if (zi < POS_W'(ZD_LEN)) begin
         byte1.data = HDR_Z[zi[HDR_IW-1:0]];
      end else if (zi == POS_W'(ZD_LEN)) begin
         byte1.data = hex_char(ZD_SUM[7:4]);
      end else if (zi == POS_W'(ZD_LEN + 1)) begin
         byte1.data = hex_char(ZD_SUM[3:0]);
      end else begin
         byte1.data = NL_BYTE;
      end
   end

   // sequencer and counters
   always_comb begin
      state_in    = state_ff;
      awaiting_in = awaiting_ff;
      count_in    = count_ff;
      line_in     = line_ff;
      k_in        = k_ff;
      p_in        = p_ff;
      p1_in       = p1_ff;
      s1_vld_in   = s1_vld_ff;
      sum_in      = sum_ff;
      row_vld_in  = row_vld_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (!awaiting_ff) begin
                  if (text_we) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     awaiting_in = 1'b1;
                  end
               end else begin
                  awaiting_in = 1'b0;
                  if (is_digit) begin
                     line_in  = ROW_W'(req_ch.rx_byte - DIGIT_ONE);
                     k_in     = '0;
                     state_in = ST_WRITE;
                  end
               end
            end
         end
         ST_WRITE: begin
            k_in = k_ff + CNT_W'(1);
            if (k_ff == CNT_W'(LINE_LEN)) begin
               row_vld_in[line_ff] = 1'b1;
               count_in  = '0;
               p_in      = '0;
               sum_in    = 8'h00;
               s1_vld_in = 1'b0;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (byte_take && (p1_ff < hex_pos)) begin
               sum_in = sum_ff + byte1.data;
            end
            if (adv) begin
               s1_vld_in = issue;
               if (issue) begin
                  p1_in = p_ff;
                  p_in  = p_ff + POS_W'(1);
               end
            end
            if (adv && !issue && (p_ff == stream_len)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         awaiting_ff <= 1'b0;
         count_ff    <= '0;
         s1_vld_ff   <= 1'b0;
         row_vld_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         awaiting_ff <= awaiting_in;
         count_ff    <= count_in;
         s1_vld_ff   <= s1_vld_in;
         row_vld_ff  <= row_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      line_ff <= line_in;
      k_ff    <= k_in;
      p_ff    <= p_in;
      p1_ff   <= p1_in;
      sum_ff  <= sum_in;
   end

   // text buffer memory
   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[text_waddr] <= req_ch.rx_byte;
      end
      if (text_re) begin
         text_q_ff <= text_mem[text_raddr];
      end
   end

   // display store memory, read data held while the pipeline stalls
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      if (store_re) begin
         store_q_ff  <= store_mem[store_raddr];
         rd_blank_ff <= !row_vld_ff[rd_row];
      end
   end

   tldf_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .byte_vld  (s1_vld_ff),
      .byte_in   (byte1),
      .byte_take (byte_take),
      .rsp       (rsp_ch)
   );

endmodule

// ----- rtl/tldf_packer.sv -----
// packs bytes two per output register transaction, or one for a run's odd last byte
// depends on tldf_pkg and tldf_rsp_if
module tldf_packer import tldf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_vld,
   input  tldf_byte_type byte_in,
   output logic          byte_take,
   tldf_rsp_if.source    rsp
);

   logic       rsp_vld_ff, rsp_vld_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       sv_ff, sv_in;
   logic       last_ff, last_in;
   logic       half_vld_ff, half_vld_in;
   logic [7:0] half_ff, half_in;
   logic       out_free;
   logic       emit;

   // a byte that completes a pair or ends the run needs a free output slot
   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign byte_take = byte_vld && ((half_vld_ff || byte_in.last) ? out_free : 1'b1);
   assign emit      = byte_take && (half_vld_ff || byte_in.last);

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      sv_in       = sv_ff;
      last_in     = last_ff;
      half_vld_in = half_vld_ff;
      half_in     = half_ff;
      if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (emit) begin
         rsp_vld_in  = 1'b1;
         last_in     = byte_in.last;
         half_vld_in = 1'b0;
         if (half_vld_ff) begin
            first_in  = half_ff;
            second_in = byte_in.data;
            sv_in     = 1'b1;
         end else begin
            first_in  = byte_in.data;
            second_in = 8'h00;
            sv_in     = 1'b0;
         end
      end else if (byte_take) begin
         half_vld_in = 1'b1;
         half_in     = byte_in.data;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         half_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         half_vld_ff <= half_vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      sv_ff     <= sv_in;
      last_ff   <= last_in;
      half_ff   <= half_in;
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.first_char   = first_ff;
   assign rsp.second_char  = second_ff;
   assign rsp.second_valid = sv_ff;
   assign rsp.last_of_run  = last_ff;

endmodule
